// ===== hdl/fatlb_pkg.sv =====
// ----------------------------------------------------------------------------
// fatlb_pkg
// Shared types, codes and the replacement LFSR step for the translation buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package fatlb_pkg;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  localparam int unsigned PAGE_W  = 32;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned STAT_W  = 32;
  localparam int unsigned LFSR_W  = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // reciprocal scaling used for the victim modulo
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 25;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [STAT_W-1:0]  stat_t;
  typedef logic [LFSR_W-1:0]  lfsr_t;

  // Fibonacci LFSR, taps 16,14,13,11, shifts right, feedback into the MSB
  function automatic lfsr_t lfsr_next(input lfsr_t s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LFSR_W-1:1]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fully_assoc_tlb_random_replace.sv =====
// ----------------------------------------------------------------------------
// fully_assoc_tlb_random_replace
// Fully associative translation buffer, lookup or add, random replacement.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  command   | start / busy       | operation, page_number, frame_number
//  result    | done (1-cycle)     | physical_frame, fault, hit_total,
//            |                    | miss_total
//
//  One beat in per cycle; busy stays low. A command beat is registered, then
//  the parallel compare over all entries and the table update happen in the
//  same cycle, and the result is registered behind them.
//  Sync reset clears valid bits, fill count and counters, and reloads the LFSR
//  look-ahead; no clearing pass, the block takes a beat the cycle after reset.
//  The receiver cannot stall: each result shows for exactly one cycle.
//
`default_nettype none

module fully_assoc_tlb_random_replace #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  wire                     operation,
  input  wire fatlb_pkg::page_t   page_number,
  input  wire fatlb_pkg::frame_t  frame_number,
  output logic                    done,
  output fatlb_pkg::frame_t       physical_frame,
  output logic                    fault,
  output fatlb_pkg::stat_t        hit_total,
  output fatlb_pkg::stat_t        miss_total
);

  import fatlb_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  // Victim = (LFSR after step) mod ENTRIES. The sequence is fixed, so the
  // modulo runs ahead of use: quotient of the step-after-next is taken with
  // a reciprocal multiply, the remainder one eviction later.
  localparam lfsr_t LA1_RST = lfsr_next(LFSR_SEED);
  localparam lfsr_t LA2_RST = lfsr_next(LA1_RST);
  localparam lfsr_t LA3_RST = lfsr_next(LA2_RST);
  localparam logic [IDX_W-1:0]   VICTIM_RST = IDX_W'(LA1_RST % ENTRIES);
  localparam lfsr_t              QUOT_RST   = lfsr_t'(LA2_RST / ENTRIES);
  localparam logic [RECIP_W-1:0] RECIP      =
    RECIP_W'((64'd1 << RECIP_SHIFT) / ENTRIES + 64'd1);
  localparam int unsigned PROD_W = LFSR_W + RECIP_W;

  // ---- command register ----
  logic   in_valid;
  logic   in_op;
  page_t  in_page;
  frame_t in_frame;

  // ---- table ----
  logic [ENTRIES-1:0] entry_valid;
  page_t              entry_page  [ENTRIES];
  frame_t             entry_frame [ENTRIES];
  logic [CNT_W-1:0]   filled_count;
  stat_t              hit_counter;
  stat_t              miss_counter;

  // ---- replacement look-ahead ----
  logic [IDX_W-1:0] victim;     // index for the next eviction
  lfsr_t            la2;        // LFSR two steps ahead
  lfsr_t            la3;        // LFSR three steps ahead
  lfsr_t            quot;       // la2 / ENTRIES

  // ---- datapath ----
  logic [ENTRIES-1:0] match;
  logic               hit;
  frame_t             hit_frame;
  logic               full;
  logic               do_add;
  logic               do_evict;
  logic [IDX_W-1:0]   wr_idx;
  logic [PROD_W-1:0]  recip_prod;
  lfsr_t              quot_next;
  lfsr_t              quot_times_n;
  lfsr_t              rem_next;

  assign busy = 1'b0;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_page[i] == in_page);
    end
    hit = |match;
    // lowest matching entry wins
    hit_frame = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_frame = entry_frame[i];
      end
    end
  end

  assign full     = (filled_count == CNT_W'(ENTRIES));
  assign do_add   = in_valid && (in_op == OP_ADD);
  assign do_evict = do_add && full;
  assign wr_idx   = full ? victim : filled_count[IDX_W-1:0];

  assign recip_prod   = PROD_W'(la3) * PROD_W'(RECIP);
  assign quot_next    = recip_prod[RECIP_SHIFT +: LFSR_W];
  assign quot_times_n = lfsr_t'(quot * lfsr_t'(ENTRIES));
  assign rem_next     = la2 - quot_times_n;

  always_ff @(posedge clk) begin
    in_op    <= operation;
    in_page  <= page_number;
    in_frame <= frame_number;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  // table payload, no reset
  always_ff @(posedge clk) begin
    if (do_add) begin
      entry_page[wr_idx]  <= in_page;
      entry_frame[wr_idx] <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      filled_count <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
      victim       <= VICTIM_RST;
      la2          <= LA2_RST;
      la3          <= LA3_RST;
      quot         <= QUOT_RST;
    end else begin
      if (do_add) begin
        entry_valid[wr_idx] <= 1'b1;
        if (!full) begin
          filled_count <= filled_count + CNT_W'(1);
        end
      end
      if (do_evict) begin
        victim <= rem_next[IDX_W-1:0];
        la2    <= la3;
        la3    <= lfsr_next(la3);
        quot   <= quot_next;
      end
      if (in_valid && (in_op == OP_LOOKUP)) begin
        if (hit) begin
          hit_counter <= hit_counter + STAT_W'(1);
        end else begin
          miss_counter <= miss_counter + STAT_W'(1);
        end
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (in_valid && (in_op == OP_LOOKUP) && hit) begin
      physical_frame <= hit_frame;
    end else begin
      physical_frame <= '0;
    end
    fault <= in_valid && (in_op == OP_LOOKUP) && !hit;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  // counters only move with a result, so they read straight out
  assign hit_total  = hit_counter;
  assign miss_total = miss_counter;

  // ---- checks ----
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("registered command gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !in_valid |=> !done)
    else $error("result without a command");

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(filled_count))
    else $error("fill count disagrees with valid bits");

  a_lookup_counts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && (in_op == OP_LOOKUP)) |=>
      (hit_counter + miss_counter) == ($past(hit_counter + miss_counter) + STAT_W'(1)))
    else $error("lookup did not bump exactly one counter");

endmodule

`default_nettype wire
